@@ hw/rtl/oversampled_soft_uart_defines.svh @@
// ----------------------------------------------------------------------------
// oversampled_soft_uart_defines
// Assertion macros used by the checker file of the soft UART.
// ----------------------------------------------------------------------------
`ifndef OVERSAMPLED_SOFT_UART_DEFINES_SVH
`define OVERSAMPLED_SOFT_UART_DEFINES_SVH

// Clocked assertion, muted while reset is high.
`define OSU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("oversampled_soft_uart: assertion failed");

// Clocked assertion that also holds across reset.
`define OSU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("oversampled_soft_uart: assertion failed");

`endif

@@ hw/rtl/osu_pkg.sv @@
// ----------------------------------------------------------------------------
// osu_pkg
// Request codes and shared types of the oversampled soft UART.
// ----------------------------------------------------------------------------
package osu_pkg;

  // request kinds carried on s_tuser
  localparam logic [1:0] REQ_RX_TICK = 2'd0;
  localparam logic [1:0] REQ_TX_TICK = 2'd1;
  localparam logic [1:0] REQ_LOAD    = 2'd2;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned RES_W   = 32;

  // receiver control driven by the transmitter
  typedef struct packed {
    logic enable;  // receiver accepts sample ticks
    logic flush;   // a load just started a transmission
  } rx_ctl_t;

  // one result, tx_line in bit 0
  typedef struct packed {
    logic [3:0]         pad;
    logic               fifo_full;
    logic [TOTAL_W-1:0] rx_total;
    logic               tx_done;
    logic               rx_valid;
    logic [BYTE_W-1:0]  rx_byte;
    logic               tx_line;
  } result_t;

endpackage

@@ hw/rtl/osu_txq.sv @@
// ----------------------------------------------------------------------------
// osu_txq
// Transmit queue storage: one write port, one registered read port. A write
// to the address being read is forwarded into the read data.
// ----------------------------------------------------------------------------
module osu_txq
  import osu_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port with write-through forwarding
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/osu_tx.sv @@
// ----------------------------------------------------------------------------
// osu_tx
// Transmitter: queue pointers, bit sequencer and receiver enable. The head
// byte is read from the queue memory in advance, addressed at the next head.
// ----------------------------------------------------------------------------
module osu_tx
  import osu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_req,
  input  logic              tick_req,
  input  logic [BYTE_W-1:0] load_byte,
  output logic              tx_line_next,
  output logic              tx_done_next,
  output logic              fifo_full_next,
  output rx_ctl_t           rx_ctl
);

  localparam int unsigned QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUMW = CNTW + 1;

  typedef enum logic [1:0] {
    TX_IDLE,
    TX_START,
    TX_DATA,
    TX_STOP
  } tx_phase_t;

  tx_phase_t         tx_phase, tx_phase_next;
  logic [2:0]        tx_bit_index, tx_bit_index_next;
  logic [QW-1:0]     queue_head, queue_head_next;
  logic [CNTW-1:0]   queue_count, queue_count_next;
  logic              tx_line_reg;
  logic              rx_enabled, rx_enabled_next;
  logic              flush;
  logic              done;

  logic              q_we;
  logic [QW-1:0]     q_waddr;
  logic [BYTE_W-1:0] head_byte;
  logic [SUMW-1:0]   tail_sum;
  logic [SUMW-1:0]   head_sum;

  // tail slot and next head, wrapped into the queue
  always_comb begin
    tail_sum = SUMW'(queue_head) + SUMW'(queue_count);
    if (tail_sum >= SUMW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUMW'(QUEUE_DEPTH);
    end
    head_sum = SUMW'(queue_head) + SUMW'(1);
    if (head_sum >= SUMW'(QUEUE_DEPTH)) begin
      head_sum = head_sum - SUMW'(QUEUE_DEPTH);
    end
  end

  assign q_waddr = tail_sum[QW-1:0];

  // next state of the sequencer
  always_comb begin
    tx_phase_next     = tx_phase;
    tx_bit_index_next = tx_bit_index;
    queue_head_next   = queue_head;
    queue_count_next  = queue_count;
    tx_line_next      = tx_line_reg;
    rx_enabled_next   = rx_enabled;
    q_we              = 1'b0;
    flush             = 1'b0;
    done              = 1'b0;
    if (load_req) begin
      if (queue_count < CNTW'(QUEUE_DEPTH)) begin
        q_we             = 1'b1;
        queue_count_next = queue_count + CNTW'(1);
        if (tx_phase == TX_IDLE) begin
          tx_phase_next     = TX_START;
          tx_bit_index_next = 3'd0;
          rx_enabled_next   = 1'b0;
          flush             = 1'b1;
        end
      end
    end else if (tick_req) begin
      case (tx_phase)
        TX_START: begin
          tx_line_next      = 1'b0;
          tx_phase_next     = TX_DATA;
          tx_bit_index_next = 3'd0;
        end
        TX_DATA: begin
          tx_line_next = head_byte[tx_bit_index];
          if (tx_bit_index == 3'd7) begin
            tx_bit_index_next = 3'd0;
            tx_phase_next     = TX_STOP;
          end else begin
            tx_bit_index_next = tx_bit_index + 3'd1;
          end
        end
        TX_STOP: begin
          tx_line_next      = 1'b1;
          tx_bit_index_next = 3'd0;
          queue_head_next   = head_sum[QW-1:0];
          if (queue_count != '0) begin
            queue_count_next = queue_count - CNTW'(1);
          end
          if (queue_count_next != '0) begin
            tx_phase_next = TX_START;
          end else begin
            tx_phase_next   = TX_IDLE;
            rx_enabled_next = 1'b1;
            done            = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_phase     <= TX_IDLE;
      tx_bit_index <= 3'd0;
      queue_head   <= '0;
      queue_count  <= '0;
      tx_line_reg  <= 1'b1;
      rx_enabled   <= 1'b1;
    end else begin
      tx_phase     <= tx_phase_next;
      tx_bit_index <= tx_bit_index_next;
      queue_head   <= queue_head_next;
      queue_count  <= queue_count_next;
      tx_line_reg  <= tx_line_next;
      rx_enabled   <= rx_enabled_next;
    end
  end

  // queue memory, read at the next head pointer
  osu_txq #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (QW)
  ) u_txq (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (load_byte),
    .raddr (queue_head_next),
    .rdata (head_byte)
  );

  assign tx_done_next   = done;
  assign fifo_full_next = (queue_count_next == CNTW'(QUEUE_DEPTH));
  assign rx_ctl.enable  = rx_enabled;
  assign rx_ctl.flush   = flush;

endmodule

@@ hw/rtl/osu_rx.sv @@
// ----------------------------------------------------------------------------
// osu_rx
// Receiver: oversampling shift, majority vote and frame sequencer.
// ----------------------------------------------------------------------------
module osu_rx
  import osu_pkg::*;
#(
  parameter int unsigned SAMPLES = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_req,
  input  logic               rx_level,
  input  rx_ctl_t            rx_ctl,
  output logic [BYTE_W-1:0]  rx_byte_next,
  output logic               rx_valid_next,
  output logic [TOTAL_W-1:0] rx_total_next
);

  localparam int unsigned SW = SAMPLES;
  localparam int unsigned CW = $clog2(SAMPLES + 1);

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_START,
    RX_DATA,
    RX_STOP
  } rx_phase_t;

  rx_phase_t          rx_phase, rx_phase_next;
  logic [SW-1:0]      sample_shift, sample_shift_next;
  logic [CW-1:0]      sample_count, sample_count_next;
  logic [2:0]         rx_bit_index, rx_bit_index_next;
  logic [BYTE_W-1:0]  rx_shift;
  logic [TOTAL_W-1:0] byte_count;

  logic [SW:0]        sh_ext;
  logic [SW-1:0]      sh;
  logic [CW-1:0]      cnt_inc;
  logic [CW-1:0]      ones;
  logic [CW:0]        twice;
  logic               bit_vote;

  // majority vote over the shifted-in samples
  always_comb begin
    sh_ext  = {sample_shift, rx_level};
    sh      = sh_ext[SW-1:0];
    cnt_inc = sample_count + CW'(1);
    ones    = '0;
    for (int k = 0; k < SAMPLES; k++) begin
      ones = ones + CW'(sh[k]);
    end
    twice    = {ones, 1'b0};
    bit_vote = (twice > (CW + 1)'(SAMPLES));
  end

  // frame sequencer
  always_comb begin
    rx_phase_next     = rx_phase;
    sample_shift_next = sample_shift;
    sample_count_next = sample_count;
    rx_bit_index_next = rx_bit_index;
    rx_byte_next      = rx_shift;
    rx_total_next     = byte_count;
    rx_valid_next     = 1'b0;
    if (rx_ctl.flush) begin
      rx_phase_next     = RX_IDLE;
      sample_shift_next = '0;
      sample_count_next = '0;
    end else if (tick_req && rx_ctl.enable) begin
      if (rx_phase == RX_IDLE) begin
        if (!rx_level) begin
          rx_phase_next     = RX_START;
          sample_shift_next = '0;
          sample_count_next = '0;
        end
      end else if (cnt_inc < CW'(SAMPLES)) begin
        sample_shift_next = sh;
        sample_count_next = cnt_inc;
      end else begin
        sample_shift_next = '0;
        sample_count_next = '0;
        case (rx_phase)
          RX_START: begin
            if (!bit_vote) begin
              rx_phase_next     = RX_DATA;
              rx_byte_next      = '0;
              rx_bit_index_next = 3'd0;
            end else begin
              rx_phase_next = RX_IDLE;
            end
          end
          RX_DATA: begin
            rx_byte_next = rx_shift | (BYTE_W'(bit_vote) << rx_bit_index);
            if (rx_bit_index == 3'd7) begin
              rx_bit_index_next = 3'd0;
              rx_phase_next     = RX_STOP;
            end else begin
              rx_bit_index_next = rx_bit_index + 3'd1;
            end
          end
          RX_STOP: begin
            // a low stop bit keeps hunting in this phase
            if (bit_vote) begin
              rx_total_next = byte_count + TOTAL_W'(1);
              rx_phase_next = RX_IDLE;
              rx_valid_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= RX_IDLE;
      sample_shift <= '0;
      sample_count <= '0;
      rx_bit_index <= 3'd0;
      rx_shift     <= '0;
      byte_count   <= '0;
    end else begin
      rx_phase     <= rx_phase_next;
      sample_shift <= sample_shift_next;
      sample_count <= sample_count_next;
      rx_bit_index <= rx_bit_index_next;
      rx_shift     <= rx_byte_next;
      byte_count   <= rx_total_next;
    end
  end

endmodule

@@ hw/rtl/osu_skid.sv @@
// ----------------------------------------------------------------------------
// osu_skid
// Two-entry output stage: an output register and a skid register, so a new
// request is taken while a result waits downstream.
// ----------------------------------------------------------------------------
module osu_skid
  import osu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_data
);

  logic    sk_valid;
  result_t sk_data;

  assign ready = !sk_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!m_valid || m_ready) begin
      if (sk_valid) begin
        m_valid  <= 1'b1;
        sk_valid <= 1'b0;
      end else begin
        m_valid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!m_valid || m_ready) begin
      m_data <= sk_valid ? sk_data : push_data;
    end else if (push) begin
      sk_data <= push_data;
    end
  end

endmodule

@@ hw/rtl/oversampled_soft_uart.sv @@
// ----------------------------------------------------------------------------
// oversampled_soft_uart
// Half-duplex 8N1 UART with majority-vote receive sampling and a transmit
// queue held in a synchronous memory.
// ----------------------------------------------------------------------------
// With m_tready held high one request enters per clock and gives one
// result, which shows on m_tdata the cycle after its request, and the
// sustained rate is one request per cycle. The transmit queue is a memory
// with a registered read, addressed every cycle at the head pointer the
// current request leaves behind, so the byte under transmission is ready
// for the next transmit tick; a load into the empty slot being read is
// forwarded into the read data. An output register plus a skid register
// keep s_tready high while one result waits; s_tready drops only when
// two results are held. Queue entries need no clearing after reset.
// ----------------------------------------------------------------------------
module oversampled_soft_uart
  import osu_pkg::*;
#(
  parameter int unsigned SAMPLES     = 3,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_level[0], load_byte[8:1], zero[15:9]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // tx_line[0], rx_byte[8:1], rx_valid[9],
                                 // tx_done[10], rx_total[26:11],
                                 // fifo_full[27], zero[31:28]
);

  logic    accept;
  logic    rx_tick;
  logic    tx_tick;
  logic    load;
  rx_ctl_t rx_ctl;
  result_t res;
  result_t out_res;

  // request decode
  assign accept  = s_tvalid && s_tready;
  assign rx_tick = accept && (s_tuser == REQ_RX_TICK);
  assign tx_tick = accept && (s_tuser == REQ_TX_TICK);
  assign load    = accept && (s_tuser == REQ_LOAD);

  osu_tx #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_tx (
    .clk            (clk),
    .rst            (rst),
    .load_req       (load),
    .tick_req       (tx_tick),
    .load_byte      (s_tdata[8:1]),
    .tx_line_next   (res.tx_line),
    .tx_done_next   (res.tx_done),
    .fifo_full_next (res.fifo_full),
    .rx_ctl         (rx_ctl)
  );

  osu_rx #(
    .SAMPLES (SAMPLES)
  ) u_rx (
    .clk           (clk),
    .rst           (rst),
    .tick_req      (rx_tick),
    .rx_level      (s_tdata[0]),
    .rx_ctl        (rx_ctl),
    .rx_byte_next  (res.rx_byte),
    .rx_valid_next (res.rx_valid),
    .rx_total_next (res.rx_total)
  );

  assign res.pad = '0;

  osu_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .ready     (s_tready),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_data    (out_res)
  );

  assign m_tdata = out_res;

endmodule

@@ hw/rtl/osu_checker.sv @@
// ----------------------------------------------------------------------------
// osu_checker
// Port-level checks of the soft UART, bound to the top level.
// ----------------------------------------------------------------------------
`include "oversampled_soft_uart_defines.svh"

module osu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a held result stays put until taken
  `OSU_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // a received byte and a finished transmission never share one result
  `OSU_ASSERT(a_rx_tx_excl, m_tvalid |-> !(m_tdata[9] && m_tdata[10]))

  // back pressure only once the output register is occupied
  `OSU_ASSERT(a_ready_stall, !s_tready |-> m_tvalid)

  // reset empties the output stage
  `OSU_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && s_tready)

endmodule

bind oversampled_soft_uart osu_checker u_osu_checker (.*);
